>>> src/round_robin_scheduler_with_blocking_unit_assert.svh
// Assertion macros for the round robin scheduler with blocking.
`ifndef ROUND_ROBIN_SCHEDULER_WITH_BLOCKING_UNIT_ASSERT_SVH
`define ROUND_ROBIN_SCHEDULER_WITH_BLOCKING_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define RRSB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rrsb: property violated");
// Condition that must never be true outside reset.
`define RRSB_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("rrsb: forbidden condition seen");
`else
`define RRSB_ASSERT(lbl, prop)
`define RRSB_NEVER(lbl, cond)
`endif

`endif

>>> src/rrsb_pkg.sv
// Shared types and constants of the round robin scheduler with blocking.
`default_nettype none

package rrsb_pkg;

  // Process slots and queue geometry
  localparam int unsigned MAX_PROCS   = 4;
  localparam int unsigned PROCS_DEF   = 4;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned PTR_W       = 2;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned PID_W       = 2;

  // Field widths
  localparam int unsigned QUANTUM_W   = 8;
  localparam int unsigned BURST_W     = 16;
  localparam int unsigned PC_W        = 19;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register reset values
  localparam int unsigned QUANTUM_RST = 2;
  localparam int unsigned BURST_RST   = 4;
  localparam int unsigned BASE_RST    = 1000;

  // Result event codes
  typedef enum logic [1:0] {
    EV_RUN    = 2'd0,
    EV_FINISH = 2'd1,
    EV_BLOCK  = 2'd2,
    EV_IDLE   = 2'd3
  } ev_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANTUM = 3'd0,
    CFG_BURST0  = 3'd1,
    CFG_BURST1  = 3'd2,
    CFG_BURST2  = 3'd3,
    CFG_BURST3  = 3'd4,
    CFG_BASE    = 3'd5
  } cfg_idx_e;

endpackage

`default_nettype wire

>>> src/round_robin_scheduler_with_blocking_unit.sv
// A slot is held in the input register on acceptance and its result in the result register.
// Throughput: one slot per cycle unless the result side stalls; each slot moves from the
// input register to the result register, held in the input register after a config write.
// Reset (async, active low): ready queue holds processes 0..NUM_PROCS-1 in order,
// blocked queue empty, counters and finished flags zero, registers at defaults.
`default_nettype none

module round_robin_scheduler_with_blocking_unit
  import rrsb_pkg::*;
#(
  parameter int unsigned NUM_PROCS = PROCS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // slot input
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [MAX_PROCS-1:0]  resource_busy_i,
  // result output
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 event_res_o,
  output logic [PID_W-1:0]           process_id_o,
  output logic                       unblocked_valid_o,
  output logic [PID_W-1:0]           unblocked_id_o,
  output logic [PC_W-1:0]            pc_after_o,
  output logic [BURST_W-1:0]         time_used_o,
  output logic [BURST_W-1:0]         run_count_o,
  output logic                       all_done_o
);

`include "round_robin_scheduler_with_blocking_unit_assert.svh"

  localparam logic [MAX_PROCS-1:0] ALL_MASK = MAX_PROCS'((1 << NUM_PROCS) - 1);
  localparam logic [CNT_W-1:0]     FULL_CNT = CNT_W'(FIFO_DEPTH);

  // Configuration registers
  logic [QUANTUM_W-1:0] quantum_q;
  logic [BURST_W-1:0]   burst_q [MAX_PROCS];
  logic [BURST_W-1:0]   base_q;
  logic [PC_W-1:0]      start_q [MAX_PROCS];
  logic [PC_W-1:0]      start_d [MAX_PROCS];
  logic [PC_W-1:0]      start_acc;
  logic                 cfg_pend_q;

  // Scheduler state
  logic [PID_W-1:0]     rdy_slot_q [FIFO_DEPTH];
  logic [PID_W-1:0]     blk_slot_q [FIFO_DEPTH];
  logic [PTR_W-1:0]     rdy_head_q, blk_head_q;
  logic [CNT_W-1:0]     rdy_cnt_q, blk_cnt_q;
  logic [BURST_W-1:0]   used_q [MAX_PROCS];
  logic [BURST_W-1:0]   runs_q [MAX_PROCS];
  logic [MAX_PROCS-1:0] fin_q;

  logic [PID_W-1:0]     rdy_slot_d [FIFO_DEPTH];
  logic [PID_W-1:0]     blk_slot_d [FIFO_DEPTH];
  logic [PTR_W-1:0]     rdy_head_d, blk_head_d;
  logic [CNT_W-1:0]     rdy_cnt_d, blk_cnt_d;
  logic [BURST_W-1:0]   used_d [MAX_PROCS];
  logic [BURST_W-1:0]   runs_d [MAX_PROCS];
  logic [MAX_PROCS-1:0] fin_d;

  // Input register
  logic                 s1_valid_q, s1_valid_d;
  logic [MAX_PROCS-1:0] busy_q;

  // Result register
  logic                 out_valid_q, out_valid_d;
  ev_e                  out_event_q, out_event_d;
  logic [PID_W-1:0]     out_pid_q, out_pid_d;
  logic                 out_ubv_q, out_ubv_d;
  logic [PID_W-1:0]     out_ubid_q, out_ubid_d;
  logic [PC_W-1:0]      out_pc_q, out_pc_d;
  logic [BURST_W-1:0]   out_tu_q, out_tu_d;
  logic [BURST_W-1:0]   out_rc_q, out_rc_d;
  logic                 out_done_q, out_done_d;

  // Slot datapath temporaries
  logic [PID_W-1:0]     head_id, run_id;
  logic [PTR_W-1:0]     wr_idx;
  logic [QUANTUM_W-1:0] quant_eff;
  logic [BURST_W-1:0]   remain, incr, used_new;

  // Handshake; a slot waits in the cycle after a config write for fresh start addresses
  logic out_free, advance, in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free && !cfg_pend_q;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_W'(QUANTUM_RST);
      for (int k = 0; k < MAX_PROCS; k++) begin
        burst_q[k] <= BURST_W'(BURST_RST);
      end
      base_q <= BURST_W'(BASE_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_QUANTUM: quantum_q  <= cfg_data_i[QUANTUM_W-1:0];
        CFG_BURST0:  burst_q[0] <= cfg_data_i[BURST_W-1:0];
        CFG_BURST1:  burst_q[1] <= cfg_data_i[BURST_W-1:0];
        CFG_BURST2:  burst_q[2] <= cfg_data_i[BURST_W-1:0];
        CFG_BURST3:  burst_q[3] <= cfg_data_i[BURST_W-1:0];
        CFG_BASE:    base_q     <= cfg_data_i[BURST_W-1:0];
        default:     ;
      endcase
    end
  end

  // Start address of each process: base plus the bursts of those before it
  always_comb begin
    start_acc = PC_W'(base_q);
    for (int k = 0; k < MAX_PROCS; k++) begin
      start_d[k] = start_acc;
      start_acc  = start_acc + PC_W'(burst_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PROCS; k++) begin
        start_q[k] <= PC_W'(BASE_RST + k * BURST_RST);
      end
      cfg_pend_q <= 1'b0;
    end else begin
      start_q    <= start_d;
      cfg_pend_q <= cfg_we_i;
    end
  end

  // One scheduling slot: blocked head check, then ready head dispatch
  always_comb begin
    rdy_slot_d = rdy_slot_q;
    blk_slot_d = blk_slot_q;
    rdy_head_d = rdy_head_q;
    blk_head_d = blk_head_q;
    rdy_cnt_d  = rdy_cnt_q;
    blk_cnt_d  = blk_cnt_q;
    used_d     = used_q;
    runs_d     = runs_q;
    fin_d      = fin_q;

    out_event_d = EV_IDLE;
    out_pid_d   = '0;
    out_ubv_d   = 1'b0;
    out_ubid_d  = '0;
    out_pc_d    = '0;
    out_tu_d    = '0;
    out_rc_d    = '0;

    head_id   = '0;
    run_id    = '0;
    wr_idx    = '0;
    quant_eff = '0;
    remain    = '0;
    incr      = '0;
    used_new  = '0;

    // blocked head: back to ready if its resource is free, else rotate
    if (blk_cnt_q != '0) begin
      head_id    = blk_slot_q[blk_head_q];
      blk_head_d = blk_head_q + 1'b1;
      blk_cnt_d  = blk_cnt_q - 1'b1;
      if (!busy_q[head_id]) begin
        if (rdy_cnt_d < FULL_CNT) begin
          wr_idx             = rdy_head_d + rdy_cnt_d[PTR_W-1:0];
          rdy_slot_d[wr_idx] = head_id;
          rdy_cnt_d          = rdy_cnt_d + 1'b1;
        end
        out_ubv_d  = 1'b1;
        out_ubid_d = head_id;
      end else if (blk_cnt_d < FULL_CNT) begin
        wr_idx             = blk_head_d + blk_cnt_d[PTR_W-1:0];
        blk_slot_d[wr_idx] = head_id;
        blk_cnt_d          = blk_cnt_d + 1'b1;
      end
    end

    // ready head: block, finish or run one quantum
    if (rdy_cnt_d != '0) begin
      run_id     = rdy_slot_d[rdy_head_d];
      rdy_head_d = rdy_head_d + 1'b1;
      rdy_cnt_d  = rdy_cnt_d - 1'b1;
      out_pid_d  = run_id;
      if (busy_q[run_id]) begin
        if (blk_cnt_d < FULL_CNT) begin
          wr_idx             = blk_head_d + blk_cnt_d[PTR_W-1:0];
          blk_slot_d[wr_idx] = run_id;
          blk_cnt_d          = blk_cnt_d + 1'b1;
        end
        out_event_d = EV_BLOCK;
      end else if (used_q[run_id] >= burst_q[run_id]) begin
        // burst already used up: finish without running
        fin_d[run_id] = 1'b1;
        out_event_d   = EV_FINISH;
      end else begin
        quant_eff = (quantum_q == '0) ? QUANTUM_W'(1) : quantum_q;
        remain    = burst_q[run_id] - used_q[run_id];
        incr      = (BURST_W'(quant_eff) < remain) ? BURST_W'(quant_eff) : remain;
        used_new  = used_q[run_id] + incr;
        used_d[run_id] = used_new;
        if (runs_q[run_id] != '1) begin
          runs_d[run_id] = runs_q[run_id] + 1'b1;
        end
        if (used_new >= burst_q[run_id]) begin
          fin_d[run_id] = 1'b1;
          out_event_d   = EV_FINISH;
        end else begin
          if (rdy_cnt_d < FULL_CNT) begin
            wr_idx             = rdy_head_d + rdy_cnt_d[PTR_W-1:0];
            rdy_slot_d[wr_idx] = run_id;
            rdy_cnt_d          = rdy_cnt_d + 1'b1;
          end
          out_event_d = EV_RUN;
        end
      end
      out_pc_d = start_q[run_id] + PC_W'(used_d[run_id]);
      out_tu_d = used_d[run_id];
      out_rc_d = runs_d[run_id];
    end

    out_done_d = ((fin_d & ALL_MASK) == ALL_MASK);
  end

  // Control and scheduler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < FIFO_DEPTH; k++) begin
        rdy_slot_q[k] <= (k < NUM_PROCS) ? PID_W'(k) : '0;
        blk_slot_q[k] <= '0;
      end
      rdy_head_q <= '0;
      blk_head_q <= '0;
      rdy_cnt_q  <= CNT_W'(NUM_PROCS);
      blk_cnt_q  <= '0;
      for (int k = 0; k < MAX_PROCS; k++) begin
        used_q[k] <= '0;
        runs_q[k] <= '0;
      end
      fin_q <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        rdy_slot_q <= rdy_slot_d;
        blk_slot_q <= blk_slot_d;
        rdy_head_q <= rdy_head_d;
        blk_head_q <= blk_head_d;
        rdy_cnt_q  <= rdy_cnt_d;
        blk_cnt_q  <= blk_cnt_d;
        used_q     <= used_d;
        runs_q     <= runs_d;
        fin_q      <= fin_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      busy_q <= resource_busy_i;
    end
    if (advance) begin
      out_event_q <= out_event_d;
      out_pid_q   <= out_pid_d;
      out_ubv_q   <= out_ubv_d;
      out_ubid_q  <= out_ubid_d;
      out_pc_q    <= out_pc_d;
      out_tu_q    <= out_tu_d;
      out_rc_q    <= out_rc_d;
      out_done_q  <= out_done_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_res_o       = out_event_q;
  assign process_id_o      = out_pid_q;
  assign unblocked_valid_o = out_ubv_q;
  assign unblocked_id_o    = out_ubid_q;
  assign pc_after_o        = out_pc_q;
  assign time_used_o       = out_tu_q;
  assign run_count_o       = out_rc_q;
  assign all_done_o        = out_done_q;

  // Every process sits in exactly one queue or is finished
  `RRSB_ASSERT(a_conserve, ((32'(rdy_cnt_q) + 32'(blk_cnt_q) + 32'($countones(fin_q & ALL_MASK))) == NUM_PROCS))
  // A reported finish leaves the process flagged as finished
  `RRSB_ASSERT(a_fin_flag, ((out_valid_q && out_event_q == EV_FINISH) |-> fin_q[out_pid_q]))
  // Once all are done, both queues stay empty
  `RRSB_ASSERT(a_done_empty, ((out_valid_q && out_done_q) |-> (rdy_cnt_q == '0 && blk_cnt_q == '0)))
  // The input side only stalls when the input register is occupied
  `RRSB_NEVER(a_stall_empty, (in_stall_o && !s1_valid_q))

endmodule

`default_nettype wire

>>> bench/tb_round_robin_scheduler_with_blocking_unit.sv
// Testbench for the round robin scheduler: directed slots, random slots, checked by predictor.
`timescale 1ns / 100ps

module tb_round_robin_scheduler_with_blocking_unit;
  import rrsb_pkg::*;

  localparam int unsigned PROCS           = PROCS_DEF;
  localparam int unsigned NUM_REGS        = CFG_BASE + 1;
  localparam int unsigned NUM_PHASES      = 7;
  localparam int unsigned ITEMS_PER_PHASE = 285;
  localparam int unsigned LONG_HOLD       = 100;
  localparam int unsigned DRAIN_SETTLE    = 4;
  localparam int unsigned STALL_LIMIT     = 3000;
  localparam int unsigned EXTREME_ROW     = 8;

  // Per-phase caps for quantum picks and burst slack
  localparam int unsigned QUANTUM_CAP [NUM_PHASES] = '{255, 7, 255, 15, 31, 7, 3};
  localparam int unsigned BURST_SLACK [NUM_PHASES] = '{0, 1000, 1000, 1000, 200, 60, 3};
  localparam int unsigned BUSY_LEVELS [5] = '{0, 15, 40, 75, 100};

  typedef struct packed {
    ev_e                ev;
    logic [PID_W-1:0]   pid;
    logic               ubv;
    logic [PID_W-1:0]   ubid;
    logic [PC_W-1:0]    pc;
    logic [BURST_W-1:0] tu;
    logic [BURST_W-1:0] rc;
    logic               done;
  } slot_result_t;

  typedef struct packed {
    logic [MAX_PROCS-1:0] busy;
    logic                 known;
    slot_result_t         res;
  } slot_row_t;

  typedef logic [CFG_DATA_W-1:0] reg_file_t [NUM_REGS];

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  // Directed slots; the first rows run with reset settings, row EXTREME_ROW onward with
  // quantum zero, maximum bursts and maximum base.
  localparam slot_row_t DIRECTED_ROWS [20] = '{
    '{4'h0, 1'b1, '{EV_RUN,   2'd0, 1'b0, 2'd0, 19'd1002,   16'd2, 16'd1, 1'b0}},
    '{4'hF, 1'b1, '{EV_BLOCK, 2'd1, 1'b0, 2'd0, 19'd1004,   16'd0, 16'd0, 1'b0}},
    '{4'hF, 1'b1, '{EV_BLOCK, 2'd2, 1'b0, 2'd0, 19'd1008,   16'd0, 16'd0, 1'b0}},
    '{4'hF, 1'b1, '{EV_BLOCK, 2'd3, 1'b0, 2'd0, 19'd1012,   16'd0, 16'd0, 1'b0}},
    '{4'hF, 1'b1, '{EV_BLOCK, 2'd0, 1'b0, 2'd0, 19'd1002,   16'd2, 16'd1, 1'b0}},
    '{4'hF, 1'b1, '{EV_IDLE,  2'd0, 1'b0, 2'd0, 19'd0,      16'd0, 16'd0, 1'b0}},
    '{4'h7, 1'b1, '{EV_RUN,   2'd3, 1'b1, 2'd3, 19'd1014,   16'd2, 16'd1, 1'b0}},
    '{4'hB, 1'b1, '{EV_BLOCK, 2'd3, 1'b1, 2'd2, 19'd1014,   16'd2, 16'd1, 1'b0}},
    '{4'h0, 1'b1, '{EV_RUN,   2'd2, 1'b1, 2'd0, 19'd196606, 16'd1, 16'd1, 1'b0}},
    '{4'h1, 1'b0, '0},
    '{4'h2, 1'b0, '0},
    '{4'h4, 1'b0, '0},
    '{4'h8, 1'b0, '0},
    '{4'h0, 1'b0, '0},
    '{4'hF, 1'b0, '0},
    '{4'h0, 1'b0, '0},
    '{4'h5, 1'b0, '0},
    '{4'hA, 1'b0, '0},
    '{4'h0, 1'b0, '0},
    '{4'h0, 1'b0, '0}
  };

  // DUT ports
  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = CFG_QUANTUM;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic [MAX_PROCS-1:0]  resource_busy_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i     = 1'b0;
  logic [1:0]            event_res_o;
  logic [PID_W-1:0]      process_id_o;
  logic                  unblocked_valid_o;
  logic [PID_W-1:0]      unblocked_id_o;
  logic [PC_W-1:0]       pc_after_o;
  logic [BURST_W-1:0]    time_used_o;
  logic [BURST_W-1:0]    run_count_o;
  logic                  all_done_o;

  // Scheduler mirror: settings, queues and per-process counters
  logic [QUANTUM_W-1:0]  quantum;
  logic [BURST_W-1:0]    burst_len [MAX_PROCS];
  logic [BURST_W-1:0]    prog_base;
  logic [PID_W-1:0]      ready_ids [$];
  logic [PID_W-1:0]      blocked_ids [$];
  logic [BURST_W-1:0]    used_units [MAX_PROCS];
  logic [BURST_W-1:0]    run_tally [MAX_PROCS];
  logic [MAX_PROCS-1:0]  finished_mask;

  slot_result_t          due_results [$];
  slot_row_t             row_answers [$];
  int unsigned           mismatches  = 0;
  int unsigned           idle_cycles = 0;
  int unsigned           burst_left  = 0;
  int unsigned           busy_pct    = 0;
  bit                    hold_req    = 1'b0;

  round_robin_scheduler_with_blocking_unit #(
    .NUM_PROCS (PROCS)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .resource_busy_i   (resource_busy_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_res_o       (event_res_o),
    .process_id_o      (process_id_o),
    .unblocked_valid_o (unblocked_valid_o),
    .unblocked_id_o    (unblocked_id_o),
    .pc_after_o        (pc_after_o),
    .time_used_o       (time_used_o),
    .run_count_o       (run_count_o),
    .all_done_o        (all_done_o)
  );

  always #1 clk_i = ~clk_i;

  // One scheduling slot: blocked head check, then ready head dispatch
  function automatic slot_result_t schedule_slot(input logic [MAX_PROCS-1:0] busy);
    slot_result_t     r;
    logic [PID_W-1:0] h;
    logic [PID_W-1:0] p;
    int unsigned      step;
    int unsigned      remain;
    int unsigned      start;
    r = '0;
    r.ev = EV_IDLE;
    if (blocked_ids.size() > 0) begin
      h = blocked_ids.pop_front();
      if (!busy[h]) begin
        ready_ids.push_back(h);
        r.ubv  = 1'b1;
        r.ubid = h;
      end else begin
        blocked_ids.push_back(h);
      end
    end
    if (ready_ids.size() > 0) begin
      p = ready_ids.pop_front();
      r.pid = p;
      if (busy[p]) begin
        blocked_ids.push_back(p);
        r.ev = EV_BLOCK;
      end else if (used_units[p] >= burst_len[p]) begin
        // burst already consumed: retire without running
        finished_mask[p] = 1'b1;
        r.ev = EV_FINISH;
      end else begin
        step   = (quantum == 0) ? 1 : quantum;
        remain = burst_len[p] - used_units[p];
        used_units[p] = used_units[p] + BURST_W'((step < remain) ? step : remain);
        if (run_tally[p] != '1) run_tally[p] = run_tally[p] + 1'b1;
        if (used_units[p] >= burst_len[p]) begin
          finished_mask[p] = 1'b1;
          r.ev = EV_FINISH;
        end else begin
          ready_ids.push_back(p);
          r.ev = EV_RUN;
        end
      end
      // process start address: base plus the bursts of lower processes
      start = prog_base;
      for (int k = 0; k < p; k++) start += burst_len[k];
      r.pc = PC_W'(start + used_units[p]);
      r.tu = used_units[p];
      r.rc = run_tally[p];
    end
    r.done = &finished_mask[PROCS-1:0];
    return r;
  endfunction

  function automatic logic [MAX_PROCS-1:0] random_busy();
    logic [MAX_PROCS-1:0] b;
    for (int k = 0; k < MAX_PROCS; k++) b[k] = ($urandom_range(0, 99) < busy_pct);
    return b;
  endfunction

  task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endtask

  // Transaction monitor: config mirror, expectation queue, result compare
  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t want;
    slot_row_t    answer;
    if (!rst_ni) begin
      quantum   = QUANTUM_RST;
      prog_base = BASE_RST;
      ready_ids   = {};
      blocked_ids = {};
      for (int k = 0; k < MAX_PROCS; k++) begin
        burst_len[k]  = BURST_RST;
        used_units[k] = '0;
        run_tally[k]  = '0;
        if (k < PROCS) ready_ids.push_back(PID_W'(k));
      end
      finished_mask = '0;
      idle_cycles   = 0;
    end else begin
      idle_cycles++;
      if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
        if (due_results.size() == 0) begin
          $error("result transaction with nothing expected");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("event_res", want.ev, event_res_o);
          check_field("process_id", want.pid, process_id_o);
          check_field("unblocked_valid", want.ubv, unblocked_valid_o);
          check_field("unblocked_id", want.ubid, unblocked_id_o);
          check_field("pc_after", want.pc, pc_after_o);
          check_field("time_used", want.tu, time_used_o);
          check_field("run_count", want.rc, run_count_o);
          check_field("all_done", want.done, all_done_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        idle_cycles = 0;
        want   = schedule_slot(resource_busy_i);
        answer = row_answers.pop_front();
        due_results.push_back(answer.known ? answer.res : want);
      end
      if (cfg_we_i) begin
        idle_cycles = 0;
        case (cfg_idx_i)
          CFG_QUANTUM: quantum = cfg_data_i[QUANTUM_W-1:0];
          CFG_BURST0, CFG_BURST1, CFG_BURST2, CFG_BURST3:
            burst_len[cfg_idx_i - CFG_BURST0] = cfg_data_i;
          CFG_BASE: prog_base = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    wait (rst_ni);
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  // Result-side backpressure: changing stall patterns plus one long hold-off
  initial begin
    stall_mode_e mode;
    int unsigned left;
    mode = STALL_NONE;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = stall_mode_e'($urandom_range(STALL_NONE, STALL_TOGGLE));
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
          default:     out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // Offer one slot transaction; bursts of back-to-back slots with random gaps
  task automatic send_slot(input slot_row_t row);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    row_answers.push_back(row);
    in_valid_i      <= 1'b1;
    resource_busy_i <= row.busy;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (due_results.size() != 0);
    repeat (DRAIN_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Quiesce, rewrite every register, poke the unmapped indexes too
  task automatic apply_setting(input reg_file_t setting);
    in_valid_i <= 1'b0;
    wait_drained();
    for (int i = CFG_QUANTUM; i <= CFG_BASE; i++) write_reg(CFG_IDX_W'(i), setting[i]);
    for (int i = CFG_BASE + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Main sequence
  initial begin
    reg_file_t   setting;
    slot_row_t   row;
    int unsigned slack;
    int unsigned room;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed slots; zero quantum, maximum bursts and base partway through
    foreach (DIRECTED_ROWS[i]) begin
      if (i == EXTREME_ROW) begin
        setting[CFG_QUANTUM] = 16'hFF00;
        for (int k = CFG_BURST0; k <= CFG_BURST3; k++) setting[k] = '1;
        setting[CFG_BASE] = '1;
        apply_setting(setting);
      end
      send_slot(DIRECTED_ROWS[i]);
    end

    // random phases; late phases shrink bursts so processes retire and all finish
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      slack = BURST_SLACK[ph];
      setting[CFG_QUANTUM] = {8'($urandom),
                              QUANTUM_W'(ph == 0 ? 255 : $urandom_range(0, QUANTUM_CAP[ph]))};
      for (int k = 0; k < MAX_PROCS; k++) begin
        if (ph < 4) begin
          setting[CFG_BURST0 + k] = 16'hFFFF - BURST_W'($urandom_range(0, slack));
        end else begin
          room = 16'hFFFF - used_units[k];
          setting[CFG_BURST0 + k] = used_units[k] +
                                    BURST_W'($urandom_range(0, (slack < room) ? slack : room));
        end
      end
      if (ph == 5) setting[CFG_BURST0 + $urandom_range(0, MAX_PROCS - 1)] = '0;
      setting[CFG_BASE] = (ph == 0) ? '0 : CFG_DATA_W'($urandom);
      apply_setting(setting);
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) busy_pct = BUSY_LEVELS[$urandom_range(0, 4)];
        row = '{random_busy(), 1'b0, '0};
        send_slot(row);
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
